@@ design/sedd_pkg.sv @@
`timescale 1ns / 1ps

package sedd_pkg;

    localparam int RISE_COUNT = 3;
    localparam int RUN_W      = 3;
    localparam int MAX_SWEEP  = 65536;

    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 16;
    localparam int SCALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int IDX_W    = 3;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_SWEEP - 1);

    localparam logic [IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SKIP      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SCALE     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DRAFT     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MISS_LIM  = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd49152;

    typedef struct packed {
        logic [7:0]         threshold_tens;
        logic [15:0]        skip_samples;
        logic [SCALE_W-1:0] cm_per_sample_q16;
        logic [15:0]        draft_cm;
        logic [15:0]        miss_limit;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        echo_found;
        logic [15:0] echo_offset;
        logic [15:0] miss_total;
    } t_report;

endpackage

@@ design/sedd_in_if.sv @@
`timescale 1ns / 1ps

interface sedd_in_if;
    logic                              valid;
    logic                              ready;
    logic [sedd_pkg::SAMPLE_W-1:0]     sample;
    logic                              last_in_sweep;

    modport source (output valid, output sample, output last_in_sweep, input ready);
    modport sink   (input valid, input sample, input last_in_sweep, output ready);
endinterface

@@ design/sedd_out_if.sv @@
`timescale 1ns / 1ps

interface sedd_out_if;
    logic        valid;
    logic        ready;
    logic        echo_found;
    logic [15:0] echo_offset;
    logic [15:0] depth_cm;
    logic [15:0] miss_total;

    modport source (output valid, output echo_found, output echo_offset, output depth_cm,
                    output miss_total, input ready);
    modport sink   (input valid, input echo_found, input echo_offset, input depth_cm,
                    input miss_total, output ready);
endinterface

@@ design/sonar_echo_depth_detector_core.sv @@
`timescale 1ns / 1ps

// Sonar echo depth detector: takes one sample per cycle unless stalled and gives at most one
// result per sweep, registered first in the input register and then, through the phase
// tracker and depth multiplier, in the output register. The only stall is a result waiting
// in the output register, which holds the input register and, once that is full, drops
// input ready.
module sonar_echo_depth_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sedd_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sedd_pkg::CFG_W-1:0]    i_cfg_data,
    sedd_in_if.sink                       i_in,
    sedd_out_if.source                    o_out
);

    sedd_pkg::t_cfg                    cfg;
    sedd_pkg::t_report                 rep;
    logic                              out_free;
    logic                              step;

    logic                              r_in_valid;
    logic [sedd_pkg::SAMPLE_W-1:0]     r_sample;
    logic                              r_last;

    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.last_in_sweep;
        end
    end

    sedd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sedd_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_sample (r_sample),
        .i_last   (r_last),
        .i_cfg    (cfg),
        .o_rep    (rep)
    );

    sedd_depth u_depth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_rep   (rep),
        .i_cfg   (cfg),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // A missed sweep carries neither an offset nor a depth.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.echo_found) |-> (o_out.echo_offset == '0 && o_out.depth_cm == '0))
        else $error("miss result with non-zero offset or depth");

    // With both stages full and the output stalled, no new transaction may be taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline is blocked");

    // A stalled result leaves the tracker state untouched.
    a_no_step_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !step)
        else $error("sample processed while result is stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

@@ design/sedd_cfg.sv @@
`timescale 1ns / 1ps

module sedd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sedd_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sedd_pkg::CFG_W-1:0]    i_cfg_data,
    output sedd_pkg::t_cfg                o_cfg
);

    sedd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_tens    <= '0;
            r_cfg.skip_samples      <= '0;
            r_cfg.cm_per_sample_q16 <= sedd_pkg::SCALE_RESET;
            r_cfg.draft_cm          <= '0;
            r_cfg.miss_limit        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sedd_pkg::CFG_THRESHOLD: r_cfg.threshold_tens    <= i_cfg_data[7:0];
                sedd_pkg::CFG_SKIP:      r_cfg.skip_samples      <= i_cfg_data[15:0];
                sedd_pkg::CFG_SCALE:     r_cfg.cm_per_sample_q16 <= i_cfg_data;
                sedd_pkg::CFG_DRAFT:     r_cfg.draft_cm          <= i_cfg_data[15:0];
                sedd_pkg::CFG_MISS_LIM:  r_cfg.miss_limit        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/sedd_track.sv @@
`timescale 1ns / 1ps

module sedd_track (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [sedd_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                             i_last,
    input  sedd_pkg::t_cfg                   i_cfg,
    output sedd_pkg::t_report                o_rep
);

    typedef enum logic [1:0] {
        PH_TX,
        PH_ECHO,
        PH_CONFIRMED
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [sedd_pkg::SAMPLE_W-1:0]     r_peak, n_peak;
    logic [sedd_pkg::RUN_W-1:0]        r_run, n_run;
    logic [sedd_pkg::POS_W-1:0]        r_pulse, n_pulse;
    logic                              r_pulse_valid, n_pulse_valid;
    logic [sedd_pkg::POS_W-1:0]        r_echo, n_echo;
    logic                              r_echo_valid, n_echo_valid;
    logic [sedd_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [sedd_pkg::POS_W:0]          r_resume, n_resume;
    logic                              r_reported, n_reported;
    logic [15:0]                       r_miss, n_miss;

    logic [11:0]                       floor_level;
    logic [11:0]                       above;
    logic [sedd_pkg::SAMPLE_W-1:0]     level;
    logic [sedd_pkg::RUN_W-1:0]        run_inc;
    logic [15:0]                       miss_inc;
    logic                              end_sweep;
    sedd_pkg::t_report                 rep;

    always_comb begin
        floor_level = {1'b0, i_cfg.threshold_tens, 3'b000}
                    + {3'b000, i_cfg.threshold_tens, 1'b0};
        above       = {4'b0000, i_sample} - floor_level;
        level       = above[7:0];
        run_inc     = r_run + 1'b1;
        miss_inc    = r_miss + 1'b1;
        end_sweep   = i_last || (r_pos >= sedd_pkg::LAST_POS);

        n_phase       = r_phase;
        n_peak        = r_peak;
        n_run         = r_run;
        n_pulse       = r_pulse;
        n_pulse_valid = r_pulse_valid;
        n_echo        = r_echo;
        n_echo_valid  = r_echo_valid;
        n_pos         = r_pos;
        n_resume      = r_resume;
        n_reported    = r_reported;
        n_miss        = r_miss;
        rep           = '0;

        if (!r_reported && ({4'b0000, i_sample} >= floor_level)) begin
            case (r_phase)
                PH_TX: begin
                    if (level > r_peak) begin
                        n_peak = level;
                        if (!r_pulse_valid) begin
                            n_pulse       = r_pos;
                            n_pulse_valid = 1'b1;
                        end
                        n_run = run_inc;
                        if (run_inc >= sedd_pkg::RUN_W'(sedd_pkg::RISE_COUNT)) begin
                            n_resume     = {1'b0, n_pulse} + {1'b0, i_cfg.skip_samples}
                                         + 17'd1;
                            n_peak       = '0;
                            n_run        = '0;
                            n_echo       = '0;
                            n_echo_valid = 1'b0;
                            n_phase      = PH_ECHO;
                        end
                    end else begin
                        n_run         = '0;
                        n_peak        = '0;
                        n_pulse       = '0;
                        n_pulse_valid = 1'b0;
                    end
                end
                PH_ECHO: begin
                    // Samples inside the skip window leave the run untouched.
                    if ({1'b0, r_pos} >= r_resume) begin
                        if (level > r_peak) begin
                            n_peak = level;
                            if (!r_echo_valid) begin
                                n_echo       = r_pos;
                                n_echo_valid = 1'b1;
                            end
                            n_run = run_inc;
                            if (run_inc >= sedd_pkg::RUN_W'(sedd_pkg::RISE_COUNT)) begin
                                n_phase = PH_CONFIRMED;
                            end
                        end else begin
                            n_run        = '0;
                            n_peak       = '0;
                            n_echo       = '0;
                            n_echo_valid = 1'b0;
                        end
                    end
                end
                PH_CONFIRMED: begin
                    rep.valid       = 1'b1;
                    rep.echo_found  = 1'b1;
                    rep.echo_offset = r_echo - r_pulse;
                    rep.miss_total  = r_miss;
                    n_reported      = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (end_sweep) begin
            if (!n_reported) begin
                n_miss         = (miss_inc == i_cfg.miss_limit) ? 16'd0 : miss_inc;
                rep.valid      = 1'b1;
                rep.echo_found = 1'b0;
                rep.echo_offset = '0;
                rep.miss_total = n_miss;
            end
            n_phase       = PH_TX;
            n_peak        = '0;
            n_run         = '0;
            n_pulse       = '0;
            n_pulse_valid = 1'b0;
            n_echo        = '0;
            n_echo_valid  = 1'b0;
            n_pos         = '0;
            n_resume      = '0;
            n_reported    = 1'b0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TX;
            r_peak        <= '0;
            r_run         <= '0;
            r_pulse       <= '0;
            r_pulse_valid <= 1'b0;
            r_echo        <= '0;
            r_echo_valid  <= 1'b0;
            r_pos         <= '0;
            r_resume      <= '0;
            r_reported    <= 1'b0;
            r_miss        <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_peak        <= n_peak;
            r_run         <= n_run;
            r_pulse       <= n_pulse;
            r_pulse_valid <= n_pulse_valid;
            r_echo        <= n_echo;
            r_echo_valid  <= n_echo_valid;
            r_pos         <= n_pos;
            r_resume      <= n_resume;
            r_reported    <= n_reported;
            r_miss        <= n_miss;
        end
    end

    assign o_rep = rep;

endmodule

@@ design/sedd_depth.sv @@
`timescale 1ns / 1ps

module sedd_depth (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  sedd_pkg::t_report    i_rep,
    input  sedd_pkg::t_cfg       i_cfg,
    output logic                 o_free,
    sedd_out_if.source           o_out
);

    logic [15+sedd_pkg::SCALE_W:0] product;
    logic [sedd_pkg::SCALE_W:0]    sum;
    logic [15:0]                   depth;

    logic        r_valid;
    logic        r_found;
    logic [15:0] r_offset;
    logic [15:0] r_depth;
    logic [15:0] r_miss;

    always_comb begin
        product = 40'(i_rep.echo_offset) * 40'(i_cfg.cm_per_sample_q16);
        sum     = {1'b0, product[39:16]} + 25'(i_cfg.draft_cm);
        if (!i_rep.echo_found) begin
            depth = '0;
        end else if (sum[24:16] != '0) begin
            depth = 16'hFFFF;
        end else begin
            depth = sum[15:0];
        end
    end

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_step && i_rep.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_step && i_rep.valid) begin
            r_found  <= i_rep.echo_found;
            r_offset <= i_rep.echo_offset;
            r_depth  <= depth;
            r_miss   <= i_rep.miss_total;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.echo_found  = r_found;
    assign o_out.echo_offset = r_offset;
    assign o_out.depth_cm    = r_depth;
    assign o_out.miss_total  = r_miss;

endmodule

@@ tb/tb_sonar_echo_depth_detector_core.sv @@
`timescale 1ns / 1ps

module tb_sonar_echo_depth_detector_core;
    import sedd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 100;
    localparam int ZERO_LIM_MISS = 24;

    typedef enum logic [1:0] {HUNT_PULSE, HUNT_ECHO, ECHO_LOCKED} hunt_e;
    typedef enum {RX_OPEN, RX_COIN, RX_MASK} rx_mode_e;
    typedef enum {SW_ECHO, SW_BROKEN, SW_NOISE} sweep_kind_e;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [15:0] depth;
        logic [15:0] misses;
    } echo_report_t;

    // Tracks the sweep state of the detector and keeps the reports it should give, oldest first.
    class depth_forecast;
        t_cfg             regs;
        hunt_e            hunt;
        logic [7:0]       peak;
        logic [RUN_W-1:0] run;
        logic [POS_W-1:0] pulse_at;
        logic [POS_W-1:0] echo_at;
        logic [POS_W-1:0] position;
        logic [POS_W:0]   resume_at;
        logic             pulse_ok;
        logic             echo_ok;
        logic             reported;
        logic [15:0]      misses;
        echo_report_t     due_reports[$];

        function new();
            regs   = '{8'd0, 16'd0, SCALE_RESET, 16'd0, 16'd0};
            misses = '0;
            restart_sweep();
        endfunction

        function void restart_sweep();
            hunt      = HUNT_PULSE;
            peak      = '0;
            run       = '0;
            pulse_at  = '0;
            pulse_ok  = 1'b0;
            echo_at   = '0;
            echo_ok   = 1'b0;
            position  = '0;
            resume_at = '0;
            reported  = 1'b0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: regs.threshold_tens    = data[7:0];
                CFG_SKIP:      regs.skip_samples      = data[15:0];
                CFG_SCALE:     regs.cm_per_sample_q16 = data;
                CFG_DRAFT:     regs.draft_cm          = data[15:0];
                CFG_MISS_LIM:  regs.miss_limit        = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void take_sample(logic [7:0] s, logic last_in);
            logic [11:0]  floor_lvl;
            logic [7:0]   v;
            logic [15:0]  pos;
            logic [15:0]  offset;
            logic [39:0]  product;
            logic [24:0]  sum;
            logic         fin;
            echo_report_t r;
            pos       = position;
            floor_lvl = 12'(regs.threshold_tens) * 12'd10;
            // The last position a sweep can hold closes it whatever the flag says.
            fin       = last_in || (pos == LAST_POS);
            if (!reported && {4'b0, s} >= floor_lvl) begin
                v = s - floor_lvl[7:0];
                case (hunt)
                    HUNT_PULSE: begin
                        if (v > peak) begin
                            peak = v;
                            if (!pulse_ok) begin
                                pulse_at = pos;
                                pulse_ok = 1'b1;
                            end
                            run = run + 1'b1;
                            if (int'(run) >= RISE_COUNT) begin
                                resume_at = {1'b0, pulse_at} + {1'b0, regs.skip_samples} + 17'd1;
                                peak      = '0;
                                run       = '0;
                                echo_at   = '0;
                                echo_ok   = 1'b0;
                                hunt      = HUNT_ECHO;
                            end
                        end else begin
                            run      = '0;
                            peak     = '0;
                            pulse_at = '0;
                            pulse_ok = 1'b0;
                        end
                    end
                    HUNT_ECHO: begin
                        if ({1'b0, pos} >= resume_at) begin
                            if (v > peak) begin
                                peak = v;
                                if (!echo_ok) begin
                                    echo_at = pos;
                                    echo_ok = 1'b1;
                                end
                                run = run + 1'b1;
                                if (int'(run) >= RISE_COUNT) begin
                                    hunt = ECHO_LOCKED;
                                end
                            end else begin
                                run     = '0;
                                peak    = '0;
                                echo_at = '0;
                                echo_ok = 1'b0;
                            end
                        end
                    end
                    default: begin
                        offset   = echo_at - pulse_at;
                        product  = 40'(offset) * 40'(regs.cm_per_sample_q16);
                        sum      = 25'(product[39:16]) + 25'(regs.draft_cm);
                        r.found  = 1'b1;
                        r.offset = offset;
                        r.depth  = (sum > 25'd65535) ? 16'hFFFF : sum[15:0];
                        r.misses = misses;
                        due_reports.push_back(r);
                        reported = 1'b1;
                    end
                endcase
            end
            if (fin) begin
                if (!reported) begin
                    misses = misses + 16'd1;
                    if (misses == regs.miss_limit) begin
                        misses = '0;
                    end
                    r = '{1'b0, 16'd0, 16'd0, misses};
                    due_reports.push_back(r);
                end
                restart_sweep();
            end else begin
                position = pos + 16'd1;
            end
        endfunction

        function string match_report(logic found, logic [15:0] offset, logic [15:0] depth,
                                     logic [15:0] total);
            echo_report_t w;
            string        msg;
            if (due_reports.size() == 0) begin
                return $sformatf(" unexpected report echo_found %0b echo_offset %0d depth_cm %0d"
                                 , found, offset, depth);
            end
            w   = due_reports.pop_front();
            msg = "";
            if (w.found !== found) begin
                msg = {msg, $sformatf(" echo_found %0b want %0b", found, w.found)};
            end
            if (w.offset !== offset) begin
                msg = {msg, $sformatf(" echo_offset %0d want %0d", offset, w.offset)};
            end
            if (w.depth !== depth) begin
                msg = {msg, $sformatf(" depth_cm %0d want %0d", depth, w.depth)};
            end
            if (w.misses !== total) begin
                msg = {msg, $sformatf(" miss_total %0d want %0d", total, w.misses)};
            end
            return msg;
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    sedd_in_if  u_in_if ();
    sedd_out_if u_out_if ();

    sonar_echo_depth_detector_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (u_in_if.sink),
        .o_out      (u_out_if.source)
    );

    always #5 i_clk = ~i_clk;

    depth_forecast fc = new();
    logic [7:0]    sweep_buf[$];
    int            err_count   = 0;
    int            sent_items  = 0;
    int            burst_left  = 0;
    bit            tx_gappy    = 1'b1;
    rx_mode_e      rx_mode     = RX_COIN;
    logic [7:0]    rx_mask     = 8'b1011_0110;
    int            hold_left   = 0;
    int            idle_cycles = 0;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 40) begin
            $display("%0t: report mismatch:%s", $time, what);
        end
    endtask

    // Offers one sample and returns once the transaction has taken place.
    task automatic push_sample(input logic [7:0] s, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = tx_gappy ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        u_in_if.valid         <= 1'b1;
        u_in_if.sample        <= s;
        u_in_if.last_in_sweep <= fin;
        do @(posedge i_clk); while (!u_in_if.ready);
        fc.take_sample(s, fin);
        sent_items++;
    endtask

    task automatic send_sweep();
        int i;
        for (i = 0; i < sweep_buf.size(); i++) begin
            push_sample(sweep_buf[i], i == sweep_buf.size() - 1);
        end
    endtask

    // Stops offering samples until every report is in and the pipeline has emptied.
    task automatic settle();
        u_in_if.valid <= 1'b0;
        while (fc.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        fc.set_reg(idx, data);
    endtask

    task automatic apply_cfg(input t_cfg c);
        put_reg(CFG_THRESHOLD, CFG_W'(c.threshold_tens));
        put_reg(CFG_SKIP, CFG_W'(c.skip_samples));
        put_reg(CFG_SCALE, c.cm_per_sample_q16);
        put_reg(CFG_DRAFT, CFG_W'(c.draft_cm));
        put_reg(CFG_MISS_LIM, CFG_W'(c.miss_limit));
        // A write beyond the last register must leave everything as it was.
        put_reg(IDX_W'($urandom_range(CFG_MISS_LIM + 1, (1 << IDX_W) - 1)), CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        case ($urandom_range(0, 9))
            0:       c.threshold_tens = 8'd255;
            1:       c.threshold_tens = 8'd25;
            default: c.threshold_tens = 8'($urandom_range(0, 12));
        endcase
        c.skip_samples      = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 10));
        c.cm_per_sample_q16 = 24'($urandom);
        c.draft_cm          = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 500));
        c.miss_limit        = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
        return c;
    endfunction

    function automatic void add_noise(input int n);
        repeat (n) sweep_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Appends a strictly rising run above the floor, starting from a level of zero.
    function automatic void add_rise(input int fl);
        int v_prev;
        int v;
        int k;
        v_prev = 0;
        for (k = 0; k < RISE_COUNT; k++) begin
            v = $urandom_range(v_prev + 1, 255 - fl - (RISE_COUNT - 1 - k));
            sweep_buf.push_back(8'(fl + v));
            v_prev = v;
        end
    endfunction

    function automatic void build_sweep(input sweep_kind_e kind);
        int fl;
        fl = int'(fc.regs.threshold_tens) * 10;
        sweep_buf.delete();
        if (kind == SW_NOISE || fl > 255 - RISE_COUNT) begin
            add_noise($urandom_range(1, 8));
            return;
        end
        add_noise($urandom_range(0, 4));
        // A sample exactly at the floor clears any partial run left by the noise.
        sweep_buf.push_back(8'(fl));
        add_rise(fl);
        add_noise((fc.regs.skip_samples <= 16 ? int'(fc.regs.skip_samples) : 0)
                  + $urandom_range(0, 3));
        sweep_buf.push_back(8'(fl));
        add_rise(fl);
        if (kind == SW_BROKEN) begin
            void'(sweep_buf.pop_back());
        end else begin
            sweep_buf.push_back(8'($urandom_range(fl, 255)));
        end
        add_noise($urandom_range(0, 3));
    endfunction

    initial begin
        u_out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                u_out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_OPEN: u_out_if.ready <= 1'b1;
                    RX_COIN: u_out_if.ready <= ($urandom_range(0, 99) < 65);
                    default: u_out_if.ready <= rx_mask[$urandom_range(0, 7)];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watch_reports
        string msg;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            msg = fc.match_report(u_out_if.echo_found, u_out_if.echo_offset,
                                  u_out_if.depth_cm, u_out_if.miss_total);
            if (msg != "") begin
                report_mismatch(msg);
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_sonar_echo_depth_detector_core failed");
        $finish;
    end

    initial begin
        int          ph;
        int          k;
        int          pick;
        int          base;
        bit          held;
        t_cfg        c;
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= CFG_THRESHOLD;
        cfg_data              <= '0;
        u_in_if.valid         <= 1'b0;
        u_in_if.sample        <= '0;
        u_in_if.last_in_sweep <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the skip is shorter than the pulse run, then a plain miss.
        sweep_buf = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd6, 8'd7, 8'd255};
        send_sweep();
        sweep_buf = '{8'd255, 8'd0};
        send_sweep();

        // High floor with saturating depth; the echo is reported on the closing sample.
        settle();
        apply_cfg('{8'd25, 16'd1, 24'hFFFFFF, 16'hFFFF, 16'd2});
        sweep_buf = '{8'd249, 8'd251, 8'd252, 8'd253, 8'd250, 8'd251, 8'd253, 8'd255, 8'd250};
        send_sweep();

        // Floor beyond the sample range: everything is ignored and the counter wraps at two.
        settle();
        apply_cfg('{8'd255, 16'd1, 24'hFFFFFF, 16'hFFFF, 16'd2});
        sweep_buf = '{8'd255};
        send_sweep();

        // A skip longer than any sweep means the echo is never looked for.
        settle();
        apply_cfg('{8'd0, 16'hFFFF, 24'd0, 16'd0, 16'hFFFF});
        sweep_buf = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};
        send_sweep();

        for (ph = 0; ph < 6; ph++) begin
            settle();
            apply_cfg(random_cfg());
            rx_mode  = rx_mode_e'(ph % 3);
            rx_mask  = 8'($urandom_range(1, 254)) | 8'h01;
            tx_gappy = (ph % 4) != 0;
            base     = sent_items;
            held     = 1'b0;
            while (sent_items - base < PHASE_ITEMS) begin
                if (ph == 2 && !held && sent_items - base > 40) begin
                    // The receiver backs off while samples keep coming, so the block fills.
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                end
                pick = $urandom_range(0, 99);
                build_sweep(pick < 70 ? SW_ECHO : pick < 85 ? SW_BROKEN : SW_NOISE);
                send_sweep();
            end
            // Sometimes leave a sweep open so that the next settings take effect mid-sweep.
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 4)) push_sample(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        // With a limit of zero every missed sweep simply counts on.
        settle();
        c            = random_cfg();
        c.miss_limit = 16'd0;
        apply_cfg(c);
        for (k = 0; k < ZERO_LIM_MISS; k++) begin
            push_sample(8'($urandom_range(0, 255)), 1'b1);
        end

        settle();
        if (err_count == 0) begin
            $display("tb_sonar_echo_depth_detector_core passed");
        end else begin
            $display("tb_sonar_echo_depth_detector_core failed");
        end
        $finish;
    end

endmodule
